[rtl/core/rgb2yuv_pkg.sv]
package rgb2yuv_pkg;

  localparam int BYTE_W = 8;
  localparam int PAIR_W = 9;   // sum of two 8-bit samples
  localparam int SUM_W  = 10;  // sum of four 8-bit samples
  localparam int DIM_W  = 13;  // geometry register width
  localparam int ADDR_W = 24;
  localparam int VAL_W  = 10;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_DEST_WIDTH    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SWAP_RB       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INTERLEAVED   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TEN_BIT       = 3'd5;

  localparam logic [DIM_W-1:0] RST_DEST_WIDTH    = 13'd1920;
  localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = 13'd1080;

  localparam int QUEUE_DEPTH = 4;

  // BT.709 limited range, 8-bit fraction
  localparam logic [16:0] K_Y_R    = 17'd47;
  localparam logic [16:0] K_Y_G    = 17'd157;
  localparam logic [16:0] K_Y_B    = 17'd16;
  localparam logic [16:0] Y_ROUND  = 17'd128;
  localparam logic [7:0]  Y_OFFSET = 8'd16;

  // chroma on 2x2 sums, 10-bit fraction; bias = rounding + 128 offset
  localparam logic [19:0] K_CB_R  = 20'd26;
  localparam logic [19:0] K_CB_G  = 20'd86;
  localparam logic [19:0] K_CB_B  = 20'd112;
  localparam logic [19:0] K_CR_R  = 20'd112;
  localparam logic [19:0] K_CR_G  = 20'd102;
  localparam logic [19:0] K_CR_B  = 20'd10;
  localparam logic [19:0] CH_BIAS = 20'd512 + 20'd131072;

  typedef struct packed {
    logic [DIM_W-1:0] dest_width;
    logic [DIM_W-1:0] source_width;
    logic [DIM_W-1:0] source_height;
    logic             swap_red_blue;
    logic             interleaved_chroma;
    logic             ten_bit_output;
  } cfg_t;

  function automatic logic [7:0] calc_luma(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    logic [16:0] acc;
    acc = 17'(r) * K_Y_R + 17'(g) * K_Y_G + 17'(b) * K_Y_B + Y_ROUND;
    return acc[15:8] + Y_OFFSET;
  endfunction

  function automatic logic [7:0] calc_cb(input logic [SUM_W-1:0] sr,
                                         input logic [SUM_W-1:0] sg,
                                         input logic [SUM_W-1:0] sb);
    logic [19:0] acc;
    // wraps mod 2^20; true value is always positive and below 2^18
    acc = CH_BIAS + 20'(sb) * K_CB_B - 20'(sr) * K_CB_R - 20'(sg) * K_CB_G;
    return acc[17:10];
  endfunction

  function automatic logic [7:0] calc_cr(input logic [SUM_W-1:0] sr,
                                         input logic [SUM_W-1:0] sg,
                                         input logic [SUM_W-1:0] sb);
    logic [19:0] acc;
    acc = CH_BIAS + 20'(sr) * K_CR_R - 20'(sg) * K_CR_G - 20'(sb) * K_CR_B;
    return acc[17:10];
  endfunction

endpackage

[rtl/core/rgb2yuv_if.sv]
interface rgb2yuv_pix_if;
  logic                              valid;
  logic                              ready;
  logic [rgb2yuv_pkg::BYTE_W-1:0]    byte_zero;
  logic [rgb2yuv_pkg::BYTE_W-1:0]    byte_one;
  logic [rgb2yuv_pkg::BYTE_W-1:0]    byte_two;

  modport source(output valid, output byte_zero, output byte_one, output byte_two,
                 input ready);
  modport sink(input valid, input byte_zero, input byte_one, input byte_two,
               output ready);
endinterface

interface rgb2yuv_res_if;
  logic                              valid;
  logic                              ready;
  logic                              sample_kind;
  logic [rgb2yuv_pkg::ADDR_W-1:0]    plane_address;
  logic [rgb2yuv_pkg::VAL_W-1:0]     first_value;
  logic [rgb2yuv_pkg::VAL_W-1:0]     second_value;
  logic                              last_of_run;

  modport source(output valid, output sample_kind, output plane_address,
                 output first_value, output second_value, output last_of_run,
                 input ready);
  modport sink(input valid, input sample_kind, input plane_address,
               input first_value, input second_value, input last_of_run,
               output ready);
endinterface

[rtl/core/rgb2yuv_front.sv]
module rgb2yuv_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int COL_W      = 12,
  parameter int ROW_W      = 12,
  parameter int WORK_W     = 63
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rgb2yuv_pix_if.sink          in_px,
  input  rgb2yuv_pkg::cfg_t    cfg,
  output logic                 push_valid,
  input  logic                 push_full,
  output logic [WORK_W-1:0]    push_data
);
  import rgb2yuv_pkg::*;

  localparam int LD_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LD_AW    = (LD_DEPTH > 1) ? $clog2(LD_DEPTH) : 1;
  localparam logic [DIM_W:0] W_MAX = (DIM_W + 1)'(MAX_WIDTH);
  localparam logic [DIM_W:0] H_MAX = (DIM_W + 1)'(MAX_HEIGHT);

  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [3*BYTE_W-1:0]   left_r;

  logic                  s1_v_r, s1_v_nxt;
  logic                  s1_chroma_r;
  logic [COL_W-1:0]      s1_col_r;
  logic [ROW_W-1:0]      s1_row_r;
  logic [BYTE_W-1:0]     s1_r_r, s1_g_r, s1_b_r;
  logic [PAIR_W-1:0]     s1_pr_r, s1_pg_r, s1_pb_r;

  logic [3*PAIR_W-1:0]   line_mem [LD_DEPTH];
  logic [3*PAIR_W-1:0]   line_rd_r;

  logic                  accept, push;
  logic [DIM_W:0]        w_eff, h_eff, col_inc, row_inc;
  logic [BYTE_W-1:0]     px_r, px_g, px_b, lf_r, lf_b;
  logic [PAIR_W-1:0]     pair_r, pair_g, pair_b;
  logic [COL_W-1:0]      col_half;
  logic [LD_AW-1:0]      slot;
  logic                  is_chroma;
  logic [SUM_W-1:0]      sum_r, sum_g, sum_b;
  logic [7:0]            luma;

  assign in_px.ready = !s1_v_r || !push_full;
  assign accept      = in_px.valid && in_px.ready;
  assign push        = s1_v_r && !push_full;

  always_comb begin
    // geometry clamp: zero means one, large values saturate
    if (cfg.source_width == '0) begin
      w_eff = (DIM_W + 1)'(1);
    end else if ({1'b0, cfg.source_width} > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = {1'b0, cfg.source_width};
    end
    if (cfg.source_height == '0) begin
      h_eff = (DIM_W + 1)'(1);
    end else if ({1'b0, cfg.source_height} > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = {1'b0, cfg.source_height};
    end

    px_r = cfg.swap_red_blue ? in_px.byte_two : in_px.byte_zero;
    px_g = in_px.byte_one;
    px_b = cfg.swap_red_blue ? in_px.byte_zero : in_px.byte_two;
    lf_r = cfg.swap_red_blue ? left_r[23:16] : left_r[7:0];
    lf_b = cfg.swap_red_blue ? left_r[7:0]   : left_r[23:16];
    pair_r = {1'b0, lf_r} + {1'b0, px_r};
    pair_g = {1'b0, left_r[15:8]} + {1'b0, px_g};
    pair_b = {1'b0, lf_b} + {1'b0, px_b};

    col_half = col_r >> 1;
    slot     = col_half[LD_AW-1:0];

    is_chroma = row_r[0] && col_r[0] &&
                ((DIM_W + 1)'(col_r) < (w_eff & ~(DIM_W + 1)'(1))) &&
                ((DIM_W + 1)'(row_r) < (h_eff & ~(DIM_W + 1)'(1)));

    col_inc = (DIM_W + 1)'(col_r) + (DIM_W + 1)'(1);
    row_inc = (DIM_W + 1)'(row_r) + (DIM_W + 1)'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end

    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= s1_v_nxt;
      if (accept && !col_r[0]) begin
        left_r <= {in_px.byte_two, in_px.byte_one, in_px.byte_zero};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_chroma_r <= is_chroma;
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_r_r      <= px_r;
      s1_g_r      <= px_g;
      s1_b_r      <= px_b;
      s1_pr_r     <= pair_r;
      s1_pg_r     <= pair_g;
      s1_pb_r     <= pair_b;
    end
  end

  // line store: even rows write pair sums, odd rows read them back
  always_ff @(posedge clk) begin
    if (accept && col_r[0] && !row_r[0]) begin
      line_mem[slot] <= {pair_b, pair_g, pair_r};
    end
    if (accept && is_chroma) begin
      line_rd_r <= line_mem[slot];
    end
  end

  always_comb begin
    luma  = calc_luma(s1_r_r, s1_g_r, s1_b_r);
    sum_r = {1'b0, s1_pr_r} + {1'b0, line_rd_r[PAIR_W-1:0]};
    sum_g = {1'b0, s1_pg_r} + {1'b0, line_rd_r[2*PAIR_W-1:PAIR_W]};
    sum_b = {1'b0, s1_pb_r} + {1'b0, line_rd_r[3*PAIR_W-1:2*PAIR_W]};
  end

  assign push_valid = push;
  assign push_data  = {s1_chroma_r, s1_row_r, s1_col_r, luma, sum_r, sum_g, sum_b};

endmodule

[rtl/core/rgb2yuv_queue.sv]
module rgb2yuv_queue #(
  parameter int W     = 63,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [W-1:0]  pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r, count_nxt;

  assign full      = (count_r == (AW + 1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slots[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (AW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/rgb2yuv_back.sv]
module rgb2yuv_back #(
  parameter int COL_W  = 12,
  parameter int ROW_W  = 12,
  parameter int WORK_W = 63
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgb2yuv_pkg::cfg_t    cfg,
  input  logic                 q_valid,
  input  logic [WORK_W-1:0]    q_data,
  output logic                 q_pop,
  rgb2yuv_res_if.source        out_res
);
  import rgb2yuv_pkg::*;

  localparam int PROD_W = (ROW_W + DIM_W > ADDR_W) ? ROW_W + DIM_W : ADDR_W;

  // unpacked work word
  logic                  w_chroma;
  logic [ROW_W-1:0]      w_row, w_row_half;
  logic [COL_W-1:0]      w_col;
  logic [7:0]            w_luma;
  logic [SUM_W-1:0]      w_sr, w_sg, w_sb;
  logic [DIM_W-1:0]      cw;
  logic [PROD_W-1:0]     lum_prod, ch_prod;

  logic                  b1_v_r, b1_v_nxt;
  logic                  phase_r, phase_nxt;
  logic                  b1_chroma_r;
  logic [COL_W-1:0]      b1_col_r;
  logic [7:0]            b1_luma_r, b1_cb_r, b1_cr_r;
  logic [ADDR_W-1:0]     b1_lum_base_r, b1_ch_base_r;

  logic                  out_v_r, out_v_nxt;
  logic                  out_kind_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [VAL_W-1:0]      out_first_r, out_second_r;
  logic                  out_last_r;

  logic                  out_load, b1_done;
  logic [COL_W-1:0]      col_half;
  logic [ADDR_W-1:0]     luma_addr, chroma_addr;

  assign {w_chroma, w_row, w_col, w_luma, w_sr, w_sg, w_sb} = q_data;

  always_comb begin
    w_row_half = w_row >> 1;
    cw         = DIM_W'(({1'b0, cfg.dest_width} + (DIM_W + 1)'(1)) >> 1);
    lum_prod   = PROD_W'(w_row) * PROD_W'(cfg.dest_width);
    ch_prod    = PROD_W'(w_row_half) * PROD_W'(cw);

    out_load = !out_v_r || out_res.ready;
    b1_done  = b1_v_r && out_load && (!b1_chroma_r || phase_r);
    q_pop    = q_valid && (!b1_v_r || b1_done);

    b1_v_nxt = b1_v_r;
    if (q_pop) begin
      b1_v_nxt = 1'b1;
    end else if (b1_done) begin
      b1_v_nxt = 1'b0;
    end

    phase_nxt = phase_r;
    if (q_pop || b1_done) begin
      phase_nxt = 1'b0;
    end else if (b1_v_r && out_load) begin
      phase_nxt = 1'b1;   // luma went out, chroma word next
    end

    out_v_nxt = out_load ? b1_v_r : out_v_r;

    col_half    = b1_col_r >> 1;
    luma_addr   = b1_lum_base_r + ADDR_W'(b1_col_r);
    chroma_addr = cfg.interleaved_chroma ?
                  ((b1_ch_base_r << 1) + (ADDR_W'(col_half) << 1)) :
                  (b1_ch_base_r + ADDR_W'(col_half));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      phase_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b1_v_r  <= b1_v_nxt;
      phase_r <= phase_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_chroma_r   <= w_chroma;
      b1_col_r      <= w_col;
      b1_luma_r     <= w_luma;
      b1_cb_r       <= calc_cb(w_sr, w_sg, w_sb);
      b1_cr_r       <= calc_cr(w_sr, w_sg, w_sb);
      b1_lum_base_r <= lum_prod[ADDR_W-1:0];
      b1_ch_base_r  <= ch_prod[ADDR_W-1:0];
    end
    if (out_load && b1_v_r) begin
      if (!phase_r) begin
        out_kind_r   <= 1'b0;
        out_addr_r   <= luma_addr;
        out_first_r  <= cfg.ten_bit_output ? {b1_luma_r, 2'b00} : {2'b00, b1_luma_r};
        out_second_r <= '0;
        out_last_r   <= !b1_chroma_r;
      end else begin
        out_kind_r   <= 1'b1;
        out_addr_r   <= chroma_addr;
        out_first_r  <= cfg.ten_bit_output ? {b1_cb_r, 2'b00} : {2'b00, b1_cb_r};
        out_second_r <= cfg.ten_bit_output ? {b1_cr_r, 2'b00} : {2'b00, b1_cr_r};
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_res.valid         = out_v_r;
  assign out_res.sample_kind   = out_kind_r;
  assign out_res.plane_address = out_addr_r;
  assign out_res.first_value   = out_first_r;
  assign out_res.second_value  = out_second_r;
  assign out_res.last_of_run   = out_last_r;

endmodule

[rtl/core/rgb_to_yuv420_bt709_converter.sv]
// RGB/BGR to BT.709 limited-range 4:2:0 converter. Pixels come in raster
// order on in_px, one word per pixel; every pixel gives a luma word on
// out_res, and the bottom-right pixel of each 2x2 block inside the even-sized
// part of the frame gives a chroma word (Cb, Cr) right after its luma word.
// Input rate is one pixel per clock unless the work queue is full. The output
// port moves one word per clock while out_res.ready is high, so on odd rows
// each chroma pixel needs two output words; a four-entry work queue between
// the pixel front end and the output back end absorbs that and lets either
// side stall alone. Line store: MAX_WIDTH/2 x 27 bits, one access per pixel
// pair (even rows write pair sums, odd rows read them), no clearing after
// reset. Geometry and mode registers sit on an APB port at byte address
// 4*index; change them only while the block is drained.
module rgb_to_yuv420_bt709_converter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rgb2yuv_pix_if.sink                          in_px,
  rgb2yuv_res_if.source                        out_res,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rgb2yuv_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rgb2yuv_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rgb2yuv_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                 pready
);
  import rgb2yuv_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  // chroma flag, row, column, luma, three 2x2 sums
  localparam int WORK_W = 1 + ROW_W + COL_W + 8 + 3 * SUM_W;

  cfg_t                cfg_r;
  logic                reg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  logic                q_push, q_full, q_pop, q_valid;
  logic [WORK_W-1:0]   q_in, q_out;

  // ---------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_width         <= RST_DEST_WIDTH;
      cfg_r.source_width       <= RST_SOURCE_WIDTH;
      cfg_r.source_height      <= RST_SOURCE_HEIGHT;
      cfg_r.swap_red_blue      <= 1'b0;
      cfg_r.interleaved_chroma <= 1'b0;
      cfg_r.ten_bit_output     <= 1'b0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_DEST_WIDTH:    cfg_r.dest_width         <= pwdata[DIM_W-1:0];
        REG_SOURCE_WIDTH:  cfg_r.source_width       <= pwdata[DIM_W-1:0];
        REG_SOURCE_HEIGHT: cfg_r.source_height      <= pwdata[DIM_W-1:0];
        REG_SWAP_RB:       cfg_r.swap_red_blue      <= pwdata[0];
        REG_INTERLEAVED:   cfg_r.interleaved_chroma <= pwdata[0];
        REG_TEN_BIT:       cfg_r.ten_bit_output     <= pwdata[0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEST_WIDTH:    prdata = APB_DATA_W'(cfg_r.dest_width);
      REG_SOURCE_WIDTH:  prdata = APB_DATA_W'(cfg_r.source_width);
      REG_SOURCE_HEIGHT: prdata = APB_DATA_W'(cfg_r.source_height);
      REG_SWAP_RB:       prdata = APB_DATA_W'(cfg_r.swap_red_blue);
      REG_INTERLEAVED:   prdata = APB_DATA_W'(cfg_r.interleaved_chroma);
      REG_TEN_BIT:       prdata = APB_DATA_W'(cfg_r.ten_bit_output);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // front end: raster counters, line store, luma and 2x2 sums
  // ---------------------------------------------------------------
  rgb2yuv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W),
    .WORK_W     (WORK_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_px      (in_px),
    .cfg        (cfg_r),
    .push_valid (q_push),
    .push_full  (q_full),
    .push_data  (q_in)
  );

  // work queue decouples pixel intake from result output
  rgb2yuv_queue #(
    .W     (WORK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  // ---------------------------------------------------------------
  // back end: addresses, chroma, luma/chroma word sequencing
  // ---------------------------------------------------------------
  rgb2yuv_back #(
    .COL_W  (COL_W),
    .ROW_W  (ROW_W),
    .WORK_W (WORK_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  // a luma word that is not last is followed at once by its chroma word
  a_chroma_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.ready && !out_res.last_of_run) |=>
      (out_res.valid && out_res.sample_kind))
    else $error("chroma word missing after non-final luma word");

  // intake only waits on a full queue, never on the output side directly
  a_intake_open: assert property (@(posedge clk) disable iff (!rst_n)
    !q_full |-> in_px.ready)
    else $error("input stalled with work queue not full");

  // luma words carry zero in the second value
  a_luma_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.sample_kind) |-> (out_res.second_value == '0))
    else $error("luma word with nonzero second value");

  // a chroma word always closes the run
  a_chroma_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.sample_kind) |-> out_res.last_of_run)
    else $error("chroma word not marked last");

endmodule
